FILE: rtl/i2c_master_bit_engine_macros.svh
// Assertion macros for the I2C master bit engine checker.
// Self-contained; taken in by the checker file.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Check a property on every rising clock edge, reset included.
`define I2CMBE_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("i2cmbe check failed");

// Check a property on every rising clock edge outside reset.
`define I2CMBE_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2cmbe check failed");

`endif

FILE: rtl/i2cmbe_pkg.sv
// Package for the I2C master bit engine: phase codes, command codes,
// field widths and the per-phase delay unit table. No dependencies.
`timescale 1ns / 1ps

package i2cmbe_pkg;

    localparam int DIVIDER_BITS = 16;
    localparam int BYTE_BITS    = 8;
    localparam int KIND_BITS    = 3;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 16;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int WAIT_BITS    = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_WAIT_LIMIT = 1'b1;

    localparam logic [DIVIDER_BITS-1:0] TICKS_RESET = 16'd8;
    localparam logic [WAIT_BITS-1:0]    WAIT_RESET  = 8'd250;

    localparam logic [KIND_BITS-1:0] KIND_START   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_STOP    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_SEND    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_WAIT    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_RECEIVE = 3'd4;

    typedef enum logic [18:0] {
        PH_IDLE = 19'h00001,
        PH_S1   = 19'h00002,
        PH_S2   = 19'h00004,
        PH_P1   = 19'h00008,
        PH_P2   = 19'h00010,
        PH_P3   = 19'h00020,
        PH_T1   = 19'h00040,
        PH_T2   = 19'h00080,
        PH_T3   = 19'h00100,
        PH_A1   = 19'h00200,
        PH_A2   = 19'h00400,
        PH_A3   = 19'h00800,
        PH_D1   = 19'h01000,
        PH_D2   = 19'h02000,
        PH_D3   = 19'h04000,
        PH_R1   = 19'h08000,
        PH_R2   = 19'h10000,
        PH_K1   = 19'h20000,
        PH_K2   = 19'h40000
    } t_phase;

    function automatic logic [1:0] step_units(input t_phase ph);
        logic [1:0] u;
        case (ph)
            PH_S1, PH_S2, PH_P1, PH_P3, PH_T1, PH_T3,
            PH_D3, PH_R1, PH_R2, PH_K1, PH_K2: u = 2'd2;
            PH_P2, PH_T2, PH_A1, PH_A2, PH_D1, PH_D2: u = 2'd1;
            default: u = 2'd0;
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/i2c_master_bit_engine.sv
// I2C master bit engine: one input transfer is one bus tick, one result per tick.
// The result of an input transfer appears in the output register in the cycle after it.
// Throughput: 1 item per cycle while the output side is ready; the output register decouples the two sides.
// Reset (i_rst_n low, synchronous): idle phase, SCL and SDA high and driven,
// counters cleared, ticks_per_unit 8, ack_wait_limit 250, output empty.
`timescale 1ns / 1ps

module i2c_master_bit_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd_valid[0], tx_byte[8:1], send_ack[9], sda_sample[10], zero[15:11]
    input  logic [i2cmbe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  logic [i2cmbe_pkg::KIND_BITS-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // scl_level[0], sda_level[1], sda_enable[2], busy_res[3], done_res[4],
    // rx_byte[12:5], ack_timeout[13], zero[15:14]
    output logic [i2cmbe_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import i2cmbe_pkg::*;

    logic [DIVIDER_BITS-1:0] r_ticks;
    logic [WAIT_BITS-1:0]    r_limit;
    t_phase                  r_phase, n_phase;
    logic [DIVIDER_BITS-1:0] r_div, n_div;
    logic [1:0]              r_cnt, n_cnt;
    logic [2:0]              r_bit, n_bit;
    logic [BYTE_BITS-1:0]    r_shift, n_shift;
    logic [WAIT_BITS-1:0]    r_wait, n_wait;
    logic                    r_ack, n_ack;
    logic                    r_scl, n_scl;
    logic                    r_sda, n_sda;
    logic                    r_en, n_en;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic                    accept;
    logic                    cmd_valid, send_ack, sda_in;
    logic [BYTE_BITS-1:0]    tx_byte;
    logic [KIND_BITS-1:0]    kind;
    logic [DIVIDER_BITS-1:0] period;
    logic [DIVIDER_BITS:0]   div_sum;
    logic [2:0]              cnt_sum;
    logic                    done, tmo, rxv;
    logic [OUT_DATA_W-1:0]   result;

    assign cmd_valid = s_axis_tdata[0];
    assign tx_byte   = s_axis_tdata[8:1];
    assign send_ack  = s_axis_tdata[9];
    assign sda_in    = s_axis_tdata[10];
    assign kind      = s_axis_tuser;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign period  = (r_ticks == '0) ? DIVIDER_BITS'(1) : r_ticks;
    assign div_sum = {1'b0, r_div} + (DIVIDER_BITS+1)'(1);
    assign cnt_sum = {1'b0, r_cnt} + 3'd1;

    always_comb begin
        n_phase = r_phase;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_wait  = r_wait;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_en    = r_en;
        done    = 1'b0;
        tmo     = 1'b0;
        rxv     = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (cmd_valid) begin
                    case (kind)
                        KIND_START: begin
                            n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b1;
                            n_phase = PH_S1; n_div = '0; n_cnt = '0;
                        end
                        KIND_STOP: begin
                            n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1;
                            n_phase = PH_P1; n_div = '0; n_cnt = '0;
                        end
                        KIND_SEND: begin
                            n_shift = tx_byte;
                            n_bit   = '0;
                            n_scl = 1'b0; n_en = 1'b1;
                            n_phase = PH_D1; n_div = '0; n_cnt = '0;
                        end
                        KIND_WAIT: begin
                            n_wait = '0;
                            n_scl = 1'b0; n_en = 1'b0;
                            n_phase = PH_A1; n_div = '0; n_cnt = '0;
                        end
                        KIND_RECEIVE: begin
                            n_shift = '0;
                            n_bit   = '0;
                            n_ack   = send_ack;
                            n_scl = 1'b0; n_en = 1'b0;
                            n_phase = PH_R1; n_div = '0; n_cnt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            PH_A3: begin
                if (!sda_in) begin
                    n_scl = 1'b0;
                    n_phase = PH_IDLE; n_div = '0; n_cnt = '0;
                    done = 1'b1;
                end else if (r_wait >= r_limit) begin
                    n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1;
                    n_phase = PH_T1; n_div = '0; n_cnt = '0;
                end else begin
                    n_wait = r_wait + WAIT_BITS'(1);
                end
            end
            default: begin
                if (div_sum >= {1'b0, period}) begin
                    n_div = '0;
                    if (cnt_sum >= {1'b0, step_units(r_phase)}) begin
                        n_cnt = '0;
                        case (r_phase)
                            PH_S1: begin n_sda = 1'b0; n_phase = PH_S2; end
                            PH_S2: begin
                                n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                            end
                            PH_P1: begin n_scl = 1'b1; n_phase = PH_P2; end
                            PH_P2: begin n_sda = 1'b1; n_phase = PH_P3; end
                            PH_P3: begin n_phase = PH_IDLE; done = 1'b1; end
                            PH_T1: begin n_scl = 1'b1; n_phase = PH_T2; end
                            PH_T2: begin n_sda = 1'b1; n_phase = PH_T3; end
                            PH_T3: begin
                                n_phase = PH_IDLE; done = 1'b1; tmo = 1'b1;
                            end
                            PH_A1: begin n_scl = 1'b1; n_phase = PH_A2; end
                            PH_A2: n_phase = PH_A3;
                            PH_D1: begin
                                n_sda   = r_shift[BYTE_BITS-1];
                                n_shift = {r_shift[BYTE_BITS-2:0], 1'b0};
                                n_phase = PH_D2;
                            end
                            PH_D2: begin n_scl = 1'b1; n_phase = PH_D3; end
                            PH_D3: begin
                                n_scl = 1'b0;
                                if (r_bit == 3'(BYTE_BITS - 1)) begin
                                    n_bit = '0; n_phase = PH_IDLE; done = 1'b1;
                                end else begin
                                    n_bit = r_bit + 3'd1; n_phase = PH_D1;
                                end
                            end
                            PH_R1: begin n_scl = 1'b1; n_phase = PH_R2; end
                            PH_R2: begin
                                n_shift = {r_shift[BYTE_BITS-2:0], sda_in};
                                if (r_bit == 3'(BYTE_BITS - 1)) begin
                                    n_bit = '0;
                                    n_scl = 1'b0; n_sda = !r_ack; n_en = 1'b1;
                                    n_phase = PH_K1;
                                end else begin
                                    n_bit = r_bit + 3'd1;
                                    n_scl = 1'b0;
                                    n_phase = PH_R1;
                                end
                            end
                            PH_K1: begin n_scl = 1'b1; n_phase = PH_K2; end
                            PH_K2: begin
                                n_scl = 1'b0; n_phase = PH_IDLE;
                                done = 1'b1; rxv = 1'b1;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end else begin
                        n_cnt = cnt_sum[1:0];
                    end
                end else begin
                    n_div = div_sum[DIVIDER_BITS-1:0];
                end
            end
        endcase
    end

    always_comb begin
        result        = '0;
        result[0]     = n_scl;
        result[1]     = n_sda;
        result[2]     = n_en;
        result[3]     = (n_phase != PH_IDLE);
        result[4]     = done;
        result[12:5]  = rxv ? n_shift : '0;
        result[13]    = tmo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
            r_limit <= WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TICKS_PER_UNIT: r_ticks <= i_cfg_wdata;
                CFG_ACK_WAIT_LIMIT: r_limit <= i_cfg_wdata[WAIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_div       <= '0;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_en        <= 1'b1;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_div       <= n_div;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_ack       <= n_ack;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_en        <= n_en;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

endmodule

FILE: rtl/i2cmbe_checker.sv
// Port-level checker for the I2C master bit engine, bound to the top level.
// Depends on i2c_master_bit_engine_macros.svh and i2cmbe_pkg.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_macros.svh"

module i2cmbe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic [i2cmbe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import i2cmbe_pkg::*;

    logic fire_done, fire_tmo, fire_rx;
    logic out_busy, out_done, out_en;

    assign fire_done = m_axis_tvalid && m_axis_tdata[4];
    assign fire_tmo  = m_axis_tvalid && m_axis_tdata[13];
    assign fire_rx   = m_axis_tvalid && (m_axis_tdata[12:5] != '0);
    assign out_busy  = m_axis_tdata[3];
    assign out_done  = m_axis_tdata[4];
    assign out_en    = m_axis_tdata[2];

    `I2CMBE_ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `I2CMBE_ASSERT_RST(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    `I2CMBE_ASSERT_RST(a_done_not_busy, i_clk, i_rst_n, fire_done |-> !out_busy)
    `I2CMBE_ASSERT_RST(a_timeout_with_done, i_clk, i_rst_n, fire_tmo |-> (out_done && out_en))
    `I2CMBE_ASSERT_RST(a_rx_only_on_done, i_clk, i_rst_n, fire_rx |-> out_done)

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_i2cmbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
);
